// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// ante |-> cons in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// ante |=> cons in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Types and constants of the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

   // default screen geometry
   localparam int DEFAULT_ROWS    = 25;
   localparam int DEFAULT_COLUMNS = 80;

   // port field widths
   localparam int KIND_W     = 3;
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int COL_PORT_W = 7;
   localparam int ROW_PORT_W = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   // transaction kinds
   localparam logic [KIND_W-1:0] KIND_PUT_CHAR   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SET_CURSOR = 3'd2;
   localparam logic [KIND_W-1:0] KIND_READ_CELL  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_VISIBILITY = 3'd4;

   // character codes
   localparam logic [CHAR_W-1:0] CH_NULL      = 8'h00;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

   // register map
   localparam logic [REG_IDX_W-1:0] REG_TEXT_ATTR   = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_CURSOR_ATTR = 1'b1;

   localparam logic [ATTR_W-1:0] TEXT_ATTR_RESET   = 8'h07;
   localparam logic [ATTR_W-1:0] CURSOR_ATTR_RESET = 8'h70;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CALC,
      ST_CLEAR,
      ST_SCROLL,
      ST_DRAIN,
      ST_SHOW,
      ST_RDOUT,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/tcce_ram.sv =====
// ----------------------------------------------------------------------------
// tcce_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/text_console_char_engine.sv =====
// Clear and scroll (a newline on the last row or a write at the last cell) are done
// by a one-cell-per-cycle sweep through the cell RAMs.
// One transaction at a time; start is taken again the cycle after the result strobe.
// Reset: synchronous; the cell RAMs are then zeroed one cell per cycle, busy high.
// Results cannot be stalled: rsp_valid is a one-cycle strobe.
// ----------------------------------------------------------------------------
// text_console_char_engine
// Text-mode screen of character/attribute cells with a cursor, held in two RAMs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_char_engine #(
   parameter int SCREEN_ROWS    = tcce_pkg::DEFAULT_ROWS,
   parameter int SCREEN_COLUMNS = tcce_pkg::DEFAULT_COLUMNS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tcce_pkg::KIND_W-1:0]       req_kind,
   input  logic [tcce_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tcce_pkg::COL_PORT_W-1:0]   req_column,
   input  logic [tcce_pkg::ROW_PORT_W-1:0]   req_row,
   input  logic                              req_visible,
   output logic                              rsp_valid,
   output logic [tcce_pkg::ROW_PORT_W-1:0]   rsp_cursor_row,
   output logic [tcce_pkg::COL_PORT_W-1:0]   rsp_cursor_column,
   output logic [tcce_pkg::CHAR_W-1:0]       rsp_cell_char,
   output logic [tcce_pkg::ATTR_W-1:0]       rsp_cell_attr,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tcce_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [tcce_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [tcce_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   localparam int CELL_COUNT    = SCREEN_ROWS * SCREEN_COLUMNS;
   localparam int CELL_W        = $clog2(CELL_COUNT);
   localparam int ROW_W         = $clog2(SCREEN_ROWS);
   localparam int COL_W         = $clog2(SCREEN_COLUMNS);
   localparam int LAST_CELL     = CELL_COUNT - 1;
   localparam int LAST_ROW_CELL = CELL_COUNT - SCREEN_COLUMNS;
   localparam int ROW_PW        = tcce_pkg::ROW_PORT_W;
   localparam int COL_PW        = tcce_pkg::COL_PORT_W;
   localparam int ATTR_W        = tcce_pkg::ATTR_W;
   localparam int CHAR_W        = tcce_pkg::CHAR_W;
   localparam int DATA_W        = tcce_pkg::CSR_DATA_W;
   localparam int REG_IDX_W     = tcce_pkg::REG_IDX_W;

   tcce_pkg::state_type state_ff, state_in;

   logic [CELL_W-1:0] cnt_ff, cnt_in;
   logic [CELL_W-1:0] cursor_cell_ff, cursor_cell_in;
   logic [ROW_W-1:0]  cursor_row_ff, cursor_row_in;
   logic [COL_W-1:0]  cursor_col_ff, cursor_col_in;
   logic              shown_ff, shown_in;
   logic [ATTR_W-1:0] text_attr_ff, text_attr_in;
   logic [ATTR_W-1:0] cursor_attr_ff, cursor_attr_in;
   logic [ROW_W-1:0]  tgt_row_ff, tgt_row_in;
   logic [COL_W-1:0]  tgt_col_ff, tgt_col_in;
   logic              is_read_ff, is_read_in;
   logic              blank_ff, blank_in;
   logic              pipe_valid_ff, pipe_valid_in;
   logic [CELL_W-1:0] pipe_addr_ff, pipe_addr_in;
   logic              pipe_fill_ff, pipe_fill_in;

   logic              accept;
   logic              csr_write;
   logic [REG_IDX_W-1:0] csr_index;
   logic [ROW_W-1:0]  sat_row;
   logic [COL_W-1:0]  sat_col;
   logic              at_last_cell, at_last_row, at_last_col, at_origin, cnt_last;
   logic [CELL_W-1:0] tgt_cell;

   logic              char_we, attr_we;
   logic [CELL_W-1:0] char_waddr, attr_waddr, rd_addr;
   logic [CHAR_W-1:0] char_wdata, char_rdata;
   logic [ATTR_W-1:0] attr_wdata, attr_rdata;

   // ------------------------------------------------------------------------
   // Cell stores
   // ------------------------------------------------------------------------
   tcce_ram #(.WIDTH(CHAR_W), .DEPTH(CELL_COUNT)) u_char_ram (
      .clock   (clock),
      .wr_en   (char_we),
      .wr_addr (char_waddr),
      .wr_data (char_wdata),
      .rd_addr (rd_addr),
      .rd_data (char_rdata)
   );

   tcce_ram #(.WIDTH(ATTR_W), .DEPTH(CELL_COUNT)) u_attr_ram (
      .clock   (clock),
      .wr_en   (attr_we),
      .wr_addr (attr_waddr),
      .wr_data (attr_wdata),
      .rd_addr (rd_addr),
      .rd_data (attr_rdata)
   );

   // ------------------------------------------------------------------------
   // Decode helpers
   // ------------------------------------------------------------------------
   assign accept       = start && !busy;
   assign sat_col      = (int'(req_column) > SCREEN_COLUMNS - 1) ?
                         COL_W'(SCREEN_COLUMNS - 1) : COL_W'(req_column);
   assign sat_row      = (int'(req_row) > SCREEN_ROWS - 1) ?
                         ROW_W'(SCREEN_ROWS - 1) : ROW_W'(req_row);
   assign at_last_cell = cursor_cell_ff == CELL_W'(LAST_CELL);
   assign at_last_row  = cursor_row_ff == ROW_W'(SCREEN_ROWS - 1);
   assign at_last_col  = cursor_col_ff == COL_W'(SCREEN_COLUMNS - 1);
   assign at_origin    = cursor_cell_ff == '0;
   assign cnt_last     = cnt_ff == CELL_W'(LAST_CELL);
   assign tgt_cell     = CELL_W'(tgt_row_ff) * CELL_W'(SCREEN_COLUMNS) + CELL_W'(tgt_col_ff);

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcce_pkg::ST_INIT: begin
            if (cnt_last) state_in = tcce_pkg::ST_IDLE;
         end
         tcce_pkg::ST_IDLE: begin
            if (start) begin
               case (req_kind)
                  tcce_pkg::KIND_PUT_CHAR: begin
                     if (req_char_code == tcce_pkg::CH_NULL) begin
                        state_in = tcce_pkg::ST_DONE;
                     end else if (req_char_code == tcce_pkg::CH_NEWLINE) begin
                        state_in = at_last_row ? tcce_pkg::ST_SCROLL : tcce_pkg::ST_SHOW;
                     end else if (req_char_code == tcce_pkg::CH_BACKSPACE) begin
                        state_in = at_origin ? tcce_pkg::ST_DONE : tcce_pkg::ST_SHOW;
                     end else begin
                        state_in = at_last_cell ? tcce_pkg::ST_SCROLL : tcce_pkg::ST_SHOW;
                     end
                  end
                  tcce_pkg::KIND_CLEAR:      state_in = tcce_pkg::ST_CLEAR;
                  tcce_pkg::KIND_SET_CURSOR: state_in = tcce_pkg::ST_CALC;
                  tcce_pkg::KIND_READ_CELL:  state_in = tcce_pkg::ST_CALC;
                  default:                   state_in = tcce_pkg::ST_DONE;
               endcase
            end
         end
         tcce_pkg::ST_CALC: begin
            state_in = is_read_ff ? tcce_pkg::ST_RDOUT : tcce_pkg::ST_SHOW;
         end
         tcce_pkg::ST_CLEAR: begin
            if (cnt_last) state_in = tcce_pkg::ST_SHOW;
         end
         tcce_pkg::ST_SCROLL: begin
            if (cnt_last) state_in = tcce_pkg::ST_DRAIN;
         end
         tcce_pkg::ST_DRAIN: state_in = tcce_pkg::ST_SHOW;
         default:            state_in = tcce_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // State outputs: RAM ports and handshake
   // ------------------------------------------------------------------------
   always_comb begin
      char_we    = 1'b0;
      attr_we    = 1'b0;
      char_waddr = cursor_cell_ff;
      attr_waddr = cursor_cell_ff;
      char_wdata = tcce_pkg::CH_BLANK;
      attr_wdata = text_attr_ff;
      rd_addr    = cnt_ff;
      busy       = state_ff != tcce_pkg::ST_IDLE;
      rsp_valid  = state_ff inside {tcce_pkg::ST_SHOW, tcce_pkg::ST_RDOUT, tcce_pkg::ST_DONE};
      case (state_ff)
         tcce_pkg::ST_INIT: begin
            char_we    = 1'b1;
            attr_we    = 1'b1;
            char_waddr = cnt_ff;
            attr_waddr = cnt_ff;
            char_wdata = '0;
            attr_wdata = '0;
         end
         tcce_pkg::ST_IDLE: begin
            // first step, at accept: unmark cursor cell, or mark it (visibility)
            if (start) begin
               case (req_kind)
                  tcce_pkg::KIND_PUT_CHAR: begin
                     if (req_char_code == tcce_pkg::CH_NEWLINE) begin
                        attr_we = 1'b1;
                     end else if (req_char_code == tcce_pkg::CH_BACKSPACE) begin
                        attr_we = !at_origin;
                     end else if (req_char_code != tcce_pkg::CH_NULL) begin
                        attr_we    = 1'b1;
                        char_we    = 1'b1;
                        char_wdata = req_char_code;
                     end
                  end
                  tcce_pkg::KIND_SET_CURSOR: attr_we = 1'b1;
                  tcce_pkg::KIND_VISIBILITY: begin
                     attr_we    = 1'b1;
                     attr_wdata = req_visible ? cursor_attr_ff : text_attr_ff;
                  end
                  default: ;
               endcase
            end
         end
         tcce_pkg::ST_CALC: rd_addr = tgt_cell;
         tcce_pkg::ST_CLEAR: begin
            char_we    = 1'b1;
            attr_we    = 1'b1;
            char_waddr = cnt_ff;
            attr_waddr = cnt_ff;
         end
         tcce_pkg::ST_SCROLL: begin
            // fetch one row below; the last row needs no fetch
            rd_addr = (int'(cnt_ff) >= LAST_ROW_CELL) ? cnt_ff :
                      cnt_ff + CELL_W'(SCREEN_COLUMNS);
         end
         tcce_pkg::ST_SHOW: begin
            attr_we    = shown_ff;
            attr_wdata = cursor_attr_ff;
            char_we    = blank_ff;
         end
         default: ;
      endcase
      // scroll write-back, in the cycle after its fetch
      if (pipe_valid_ff) begin
         char_we    = 1'b1;
         attr_we    = 1'b1;
         char_waddr = pipe_addr_ff;
         attr_waddr = pipe_addr_ff;
         char_wdata = pipe_fill_ff ? tcce_pkg::CH_BLANK : char_rdata;
         attr_wdata = pipe_fill_ff ? text_attr_ff : attr_rdata;
      end
   end

   assign rsp_cursor_row    = ROW_PW'(cursor_row_ff);
   assign rsp_cursor_column = COL_PW'(cursor_col_ff);
   assign rsp_cell_char     = (state_ff == tcce_pkg::ST_RDOUT) ? char_rdata : '0;
   assign rsp_cell_attr     = (state_ff == tcce_pkg::ST_RDOUT) ? attr_rdata : '0;

   // ------------------------------------------------------------------------
   // Cursor, sweep counter and item registers
   // ------------------------------------------------------------------------
   always_comb begin
      cnt_in         = cnt_ff;
      cursor_cell_in = cursor_cell_ff;
      cursor_row_in  = cursor_row_ff;
      cursor_col_in  = cursor_col_ff;
      shown_in       = shown_ff;
      tgt_row_in     = tgt_row_ff;
      tgt_col_in     = tgt_col_ff;
      is_read_in     = is_read_ff;
      blank_in       = blank_ff;
      pipe_valid_in  = state_ff == tcce_pkg::ST_SCROLL;
      pipe_addr_in   = cnt_ff;
      pipe_fill_in   = int'(cnt_ff) >= LAST_ROW_CELL;

      if (state_ff == tcce_pkg::ST_INIT || state_ff == tcce_pkg::ST_CLEAR ||
          state_ff == tcce_pkg::ST_SCROLL) begin
         cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
      end

      if (accept) begin
         blank_in   = 1'b0;
         is_read_in = req_kind == tcce_pkg::KIND_READ_CELL;
         tgt_row_in = sat_row;
         tgt_col_in = sat_col;
         case (req_kind)
            tcce_pkg::KIND_PUT_CHAR: begin
               if (req_char_code == tcce_pkg::CH_NEWLINE) begin
                  cursor_col_in = '0;
                  if (at_last_row) begin
                     cursor_cell_in = CELL_W'(LAST_ROW_CELL);
                  end else begin
                     cursor_cell_in = cursor_cell_ff + CELL_W'(SCREEN_COLUMNS)
                                      - CELL_W'(cursor_col_ff);
                     cursor_row_in  = cursor_row_ff + 1'b1;
                  end
               end else if (req_char_code == tcce_pkg::CH_BACKSPACE) begin
                  if (!at_origin) begin
                     blank_in       = 1'b1;
                     cursor_cell_in = cursor_cell_ff - 1'b1;
                     if (cursor_col_ff == '0) begin
                        cursor_col_in = COL_W'(SCREEN_COLUMNS - 1);
                        cursor_row_in = cursor_row_ff - 1'b1;
                     end else begin
                        cursor_col_in = cursor_col_ff - 1'b1;
                     end
                  end
               end else if (req_char_code != tcce_pkg::CH_NULL) begin
                  if (at_last_cell) begin
                     cursor_cell_in = CELL_W'(LAST_ROW_CELL);
                     cursor_col_in  = '0;
                  end else begin
                     cursor_cell_in = cursor_cell_ff + 1'b1;
                     if (at_last_col) begin
                        cursor_col_in = '0;
                        cursor_row_in = cursor_row_ff + 1'b1;
                     end else begin
                        cursor_col_in = cursor_col_ff + 1'b1;
                     end
                  end
               end
            end
            tcce_pkg::KIND_CLEAR: begin
               cursor_cell_in = '0;
               cursor_row_in  = '0;
               cursor_col_in  = '0;
            end
            tcce_pkg::KIND_VISIBILITY: shown_in = req_visible;
            default: ;
         endcase
      end

      if (state_ff == tcce_pkg::ST_CALC && !is_read_ff) begin
         cursor_cell_in = tgt_cell;
         cursor_row_in  = tgt_row_ff;
         cursor_col_in  = tgt_col_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Register file
   // ------------------------------------------------------------------------
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[tcce_pkg::CSR_ADDR_W-1:2];
   assign pready    = 1'b1;

   always_comb begin
      text_attr_in   = text_attr_ff;
      cursor_attr_in = cursor_attr_ff;
      if (csr_write) begin
         case (csr_index)
            tcce_pkg::REG_TEXT_ATTR:   text_attr_in   = pwdata[ATTR_W-1:0];
            tcce_pkg::REG_CURSOR_ATTR: cursor_attr_in = pwdata[ATTR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         tcce_pkg::REG_TEXT_ATTR:   prdata = DATA_W'(text_attr_ff);
         tcce_pkg::REG_CURSOR_ATTR: prdata = DATA_W'(cursor_attr_ff);
         default:                   prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Flops
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tcce_pkg::ST_INIT;
         cnt_ff         <= '0;
         cursor_cell_ff <= '0;
         cursor_row_ff  <= '0;
         cursor_col_ff  <= '0;
         shown_ff       <= 1'b1;
         text_attr_ff   <= tcce_pkg::TEXT_ATTR_RESET;
         cursor_attr_ff <= tcce_pkg::CURSOR_ATTR_RESET;
         is_read_ff     <= 1'b0;
         blank_ff       <= 1'b0;
         pipe_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         cursor_cell_ff <= cursor_cell_in;
         cursor_row_ff  <= cursor_row_in;
         cursor_col_ff  <= cursor_col_in;
         shown_ff       <= shown_in;
         text_attr_ff   <= text_attr_in;
         cursor_attr_ff <= cursor_attr_in;
         is_read_ff     <= is_read_in;
         blank_ff       <= blank_in;
         pipe_valid_ff  <= pipe_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_row_ff   <= tgt_row_in;
      tgt_col_ff   <= tgt_col_in;
      pipe_addr_ff <= pipe_addr_in;
      pipe_fill_ff <= pipe_fill_in;
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `ASSERT_IMPLIES(a_rsp_while_busy, clock, reset, rsp_valid, busy,
      "result strobe outside a transaction")
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy,
      "accepted transaction did not raise busy")
   `ASSERT_IMPLIES(a_pipe_in_scroll, clock, reset, pipe_valid_ff,
      state_ff == tcce_pkg::ST_SCROLL || state_ff == tcce_pkg::ST_DRAIN,
      "scroll write-back outside a scroll")
   `ASSERT_IMPLIES(a_cursor_consistent, clock, reset, 1'b1,
      cursor_cell_ff == CELL_W'(cursor_row_ff) * CELL_W'(SCREEN_COLUMNS) + CELL_W'(cursor_col_ff),
      "cursor cell disagrees with row and column")
   `ASSERT_IMPLIES(a_cursor_in_range, clock, reset, 1'b1,
      int'(cursor_row_ff) < SCREEN_ROWS && int'(cursor_col_ff) < SCREEN_COLUMNS,
      "cursor off screen")

endmodule
